/* rtl/fts_pkg.sv */
// Shared types, constants and helper functions for the FAT timestamp converter.
package fts_pkg;

    // Number of register stages from the input to the output register.
    localparam int NSTAGE = 8;

    // Operation codes carried in the opcode field.
    localparam logic OP_DOS2UNIX = 1'b0;
    localparam logic OP_UNIX2DOS = 1'b1;

    // Calendar constants.
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [16:0] DAYS_EPOCH_D2U  = 17'd3653;
    localparam logic [14:0] DAYS_EPOCH_U2D  = 15'd3652;
    localparam logic [14:0] DAYS_PER_YEAR   = 15'd365;

    // Reciprocals for the constant divisions.
    // 86400 = 128 * 675: the shifted value divides by 675 as (v * K) >> 35.
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    localparam int          SHIFT_675  = 35;
    localparam logic [17:0] RECIP_3600 = 18'd149131;
    localparam int          SHIFT_3600 = 29;
    localparam logic [14:0] RECIP_365  = 15'd22983;
    localparam int          SHIFT_365  = 23;
    localparam logic [12:0] RECIP_60   = 13'd4370;
    localparam int          SHIFT_60   = 18;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        dos_time_in;
        logic [15:0]        dos_date_in;
        logic signed [31:0] unix_seconds_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] unix_seconds_out;
        logic [15:0]        dos_time_out;
        logic [15:0]        dos_date_out;
    } out_t;

    // Pipeline control shared by the datapath modules.
    typedef struct packed {
        logic [NSTAGE:1] en;
        logic            op_last;
    } fts_ctrl_t;

    // Day of year at which each month starts; unused codes read as zero.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Timezone offset in seconds.
    function automatic logic signed [16:0] tz_to_secs(input logic signed [4:0] tz);
        logic signed [16:0] t;
        t = 17'(tz);
        return t * $signed({5'd0, SECS_PER_HOUR});
    endfunction

endpackage

/* rtl/fts_ctrl.sv */
// Valid bits, stage enables and opcode tracking for the converter pipeline.
module fts_ctrl
    import fts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_opcode,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output fts_ctrl_t ctrl
);

    logic [NSTAGE:1]   v_reg;
    logic [NSTAGE:1]   v_next;
    logic [NSTAGE-1:1] op_reg;
    logic [NSTAGE-1:1] op_next;
    logic [NSTAGE:1]   en;

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || !out_stall;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    always_comb
    begin
        v_next  = v_reg;
        op_next = op_reg;
        if (en[1])
        begin
            v_next[1]  = in_valid;
            op_next[1] = in_opcode;
        end
        for (int k = 2; k <= NSTAGE; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k - 1];
            end
        end
        for (int k = 2; k <= NSTAGE - 1; k++)
        begin
            if (en[k])
            begin
                op_next[k] = op_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            op_reg <= '0;
        end
        else
        begin
            v_reg  <= v_next;
            op_reg <= op_next;
        end
    end

    assign in_stall     = !en[1];
    assign out_valid    = v_reg[NSTAGE];
    assign ctrl.en      = en;
    assign ctrl.op_last = op_reg[NSTAGE-1];

endmodule

/* rtl/fts_d2u.sv */
// DOS time and date to Unix seconds datapath, stages one through seven.
module fts_d2u
    import fts_pkg::*;
(
    input  logic               clk,
    input  fts_ctrl_t          ctrl,
    input  logic [15:0]        dos_time,
    input  logic [15:0]        dos_date,
    input  logic signed [4:0]  tz,
    output logic [31:0]        unix_res
);

    logic [3:0]         mf;
    logic [6:0]         yr;
    logic [8:0]         mstart;
    logic               corr;

    logic [15:0]        days_reg, days_next;
    logic [16:0]        sec_reg, sec_next;
    logic signed [16:0] tzs_reg, tzs_next;
    logic [31:0]        prod_reg, prod_next;
    logic signed [18:0] sum_reg, sum_next;
    logic [31:0]        total_next;
    logic [31:0]        total_reg [3:NSTAGE-1];

    // Stage one: day count and time of day.
    always_comb
    begin
        mf        = dos_date[8:5];
        yr        = dos_date[15:9];
        mstart    = (mf == 4'd0) ? 9'd0 : month_start(mf - 4'd1);
        corr      = (yr[1:0] == 2'd0) && (mf <= 4'd2);
        days_next = 16'(17'(dos_date[4:0]) + 17'(mstart) + 17'(yr[6:2])
                        + 17'(yr) * 17'(DAYS_PER_YEAR) + DAYS_EPOCH_D2U
                        - 17'd1 - 17'(corr));
        sec_next  = 17'({dos_time[4:0], 1'b0}) + 17'(dos_time[10:5]) * 17'd60
                    + 17'(dos_time[15:11]) * 17'(SECS_PER_HOUR);
        tzs_next  = tz_to_secs(tz);
    end

    // Stage two: scale days to seconds, fold the timezone into the time of day.
    always_comb
    begin
        prod_next = 32'(33'(days_reg) * 33'(SECS_PER_DAY));
        sum_next  = $signed({2'b00, sec_reg}) + 19'(tzs_reg);
    end

    // Stage three: final sum, wrapped to 32 bits.
    assign total_next = prod_reg + $unsigned(32'(sum_reg));

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            days_reg <= days_next;
            sec_reg  <= sec_next;
            tzs_reg  <= tzs_next;
        end
        if (ctrl.en[2])
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
        if (ctrl.en[3])
        begin
            total_reg[3] <= total_next;
        end
        for (int k = 4; k <= NSTAGE - 1; k++)
        begin
            if (ctrl.en[k])
            begin
                total_reg[k] <= total_reg[k - 1];
            end
        end
    end

    assign unix_res = total_reg[NSTAGE-1];

endmodule

/* rtl/fts_u2d.sv */
// Unix seconds to DOS time and date datapath, stages one through seven plus output logic.
module fts_u2d
    import fts_pkg::*;
(
    input  logic               clk,
    input  fts_ctrl_t          ctrl,
    input  logic signed [31:0] unix_in,
    input  logic signed [4:0]  tz,
    output logic [15:0]        dos_time_res,
    output logic [15:0]        dos_date_res
);

    function automatic logic [14:0] year_base(input logic [5:0] y);
        return 15'((7'(y) + 7'd3) >> 2) + 15'(y) * DAYS_PER_YEAR;
    endfunction

    // Stage registers.
    logic [31:0] x_reg, x_next;
    logic        neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic [31:0] m2_reg, m2_next, m3_reg;
    logic [14:0] q_reg, q_next;
    logic [16:0] r4_reg, r4_next, r5_reg;
    logic [14:0] day4_reg, day4_next, day5_reg;
    logic [4:0]  c5_reg, c5_next, c6_reg, c7_reg;
    logic [5:0]  y0_reg, y0_next;
    logic [11:0] rem6_reg, rem6_next, rem7_reg;
    logic [5:0]  y6_reg, y6_next, y7_reg;
    logic [8:0]  drem_reg, drem_next;
    logic [5:0]  b7_reg, b7_next;
    logic [8:0]  nl7_reg, nl7_next;
    logic [3:0]  mon7_reg, mon7_next;

    // Intermediate products.
    logic [50:0] qp;
    logic [34:0] cp;
    logic [29:0] yp;
    logic [24:0] bp;
    logic [14:0] base0, base1;
    logic        year_back;
    logic        leap;
    logic [3:0]  cnt;
    logic [5:0]  a8;
    logic [15:0] tpart;

    // Stage one: apply the timezone.
    assign x_next = $unsigned(unix_in) - $unsigned(32'(tz_to_secs(tz)));

    // Stage two: magnitude and sign.
    assign m2_next = x_reg[31] ? (32'd0 - x_reg) : x_reg;

    // Stage three: whole days of the magnitude.
    always_comb
    begin
        qp     = 51'(m2_reg[31:7]) * 51'(RECIP_675);
        q_next = qp[SHIFT_675 +: 15];
    end

    // Stage four: seconds within the day, day index since 1980 with clamp.
    always_comb
    begin
        r4_next   = 17'(m3_reg - 32'(q_reg) * 32'(SECS_PER_DAY));
        day4_next = (neg3_reg || (q_reg < DAYS_EPOCH_U2D)) ? 15'd0
                                                           : q_reg - DAYS_EPOCH_U2D;
    end

    // Stage five: hour of day and year estimate.
    always_comb
    begin
        cp      = 35'(r4_reg) * 35'(RECIP_3600);
        c5_next = cp[SHIFT_3600 +: 5];
        yp      = 30'(day4_reg) * 30'(RECIP_365);
        y0_next = yp[SHIFT_365 +: 6];
    end

    // Stage six: seconds within the hour, year correction and day of year.
    always_comb
    begin
        rem6_next = 12'(r5_reg - 17'(c5_reg) * 17'(SECS_PER_HOUR));
        base0     = year_base(y0_reg);
        base1     = year_base(y0_reg - 6'd1);
        year_back = base0 > day5_reg;
        y6_next   = year_back ? y0_reg - 6'd1 : y0_reg;
        drem_next = 9'(day5_reg - (year_back ? base1 : base0));
    end

    // Stage seven: minutes and month lookup.
    always_comb
    begin
        bp      = 25'(rem6_reg) * 25'(RECIP_60);
        b7_next = bp[SHIFT_60 +: 6];
        leap    = (y6_reg[1:0] == 2'd0);
        if (leap && (drem_reg == 9'd59))
        begin
            nl7_next = 9'd59;
        end
        else
        begin
            nl7_next = (!leap || (drem_reg <= 9'd59)) ? drem_reg : drem_reg - 9'd1;
        end
        cnt = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (month_start(4'(i)) <= nl7_next)
            begin
                cnt = cnt + 4'd1;
            end
        end
        if (leap && (drem_reg == 9'd59))
        begin
            mon7_next = 4'd2;
        end
        else
        begin
            mon7_next = (cnt == 4'd0) ? 4'd1 : cnt;
        end
    end

    // Output stage logic: pack the time and date words.
    always_comb
    begin
        a8           = 6'(rem7_reg - 12'(b7_reg) * 12'd60);
        tpart        = 16'(a8[5:1]) + 16'(b7_reg) * 16'd32 + 16'(c7_reg) * 16'd2048;
        dos_time_res = neg7_reg ? (16'd0 - tpart) : tpart;
        dos_date_res = 16'(nl7_reg) - 16'(month_start(mon7_reg - 4'd1)) + 16'd1
                       + 16'(mon7_reg) * 16'd32 + 16'(y7_reg) * 16'd512;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            x_reg <= x_next;
        end
        if (ctrl.en[2])
        begin
            m2_reg   <= m2_next;
            neg2_reg <= x_reg[31];
        end
        if (ctrl.en[3])
        begin
            q_reg    <= q_next;
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
        end
        if (ctrl.en[4])
        begin
            r4_reg   <= r4_next;
            day4_reg <= day4_next;
            neg4_reg <= neg3_reg;
        end
        if (ctrl.en[5])
        begin
            c5_reg   <= c5_next;
            y0_reg   <= y0_next;
            r5_reg   <= r4_reg;
            day5_reg <= day4_reg;
            neg5_reg <= neg4_reg;
        end
        if (ctrl.en[6])
        begin
            rem6_reg <= rem6_next;
            y6_reg   <= y6_next;
            drem_reg <= drem_next;
            c6_reg   <= c5_reg;
            neg6_reg <= neg5_reg;
        end
        if (ctrl.en[7])
        begin
            b7_reg   <= b7_next;
            nl7_reg  <= nl7_next;
            mon7_reg <= mon7_next;
            rem7_reg <= rem6_reg;
            y7_reg   <= y6_reg;
            c7_reg   <= c6_reg;
            neg7_reg <= neg6_reg;
        end
    end

endmodule

/* rtl/fat_timestamp_converter.sv */
// Top level of the FAT timestamp converter: control, both datapaths and the output register.
//
// Usage:
// The input channel carries one conversion request per transaction: an opcode and the
// DOS time word, DOS date word and Unix seconds. Opcode zero turns the DOS words into
// signed Unix seconds; opcode one splits Unix seconds into DOS time and date words.
// The field that the opcode does not produce reads as zero in the result.
// A transaction is taken at a rising edge where in_valid is high and in_stall is low;
// the output channel hands over results the same way with out_valid and out_stall.
// The timezone offset in whole hours is written through cfg_write and cfg_data while
// the block is idle; it is applied to every later transaction.
// The pipeline has eight register stages, the last of which is the output register. With
// no stall the block takes and delivers one transaction per cycle.
// Stall from the receiver holds the output register and closes the pipeline from the
// back; stages that hold bubbles keep moving, so in_stall rises only when every stage
// is full. Nothing is dropped or repeated.
// Reset clears all valid bits and sets the timezone offset to zero.
module fat_timestamp_converter
    import fts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              cfg_write,
    input  logic signed [4:0] cfg_data
);

    logic signed [4:0] tz_reg;
    fts_ctrl_t         ctrl_s;
    logic [31:0]       unix_res;
    logic [15:0]       dos_time_res;
    logic [15:0]       dos_date_res;
    out_t              out_reg;
    out_t              out_next;

    // Timezone configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg <= '0;
        end
        else if (cfg_write)
        begin
            tz_reg <= cfg_data;
        end
    end

    // Valid bits and stage enables.
    fts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl_s)
    );

    // Both directions are computed for every transaction; the opcode picks one at the end.
    fts_d2u u_d2u (
        .clk      (clk),
        .ctrl     (ctrl_s),
        .dos_time (in_data.dos_time_in),
        .dos_date (in_data.dos_date_in),
        .tz       (tz_reg),
        .unix_res (unix_res)
    );

    fts_u2d u_u2d (
        .clk          (clk),
        .ctrl         (ctrl_s),
        .unix_in      (in_data.unix_seconds_in),
        .tz           (tz_reg),
        .dos_time_res (dos_time_res),
        .dos_date_res (dos_date_res)
    );

    // Output register selection: the unused direction reads as zero.
    always_comb
    begin
        if (ctrl_s.op_last == OP_UNIX2DOS)
        begin
            out_next.unix_seconds_out = '0;
            out_next.dos_time_out     = dos_time_res;
            out_next.dos_date_out     = dos_date_res;
        end
        else
        begin
            out_next.unix_seconds_out = $signed(unix_res);
            out_next.dos_time_out     = '0;
            out_next.dos_date_out     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_s.en[NSTAGE])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    // An empty output register means no stage can be blocked.
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

    // A result carries either Unix seconds or DOS words, never both.
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.dos_time_out == 16'd0 && out_data.dos_date_out == 16'd0)
                       || out_data.unix_seconds_out == 32'sd0))
        else $error("result mixes both conversion directions");

    // A stalled pipeline with a full output stage takes no new transaction.
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && ctrl_s.en == '0) |-> in_stall)
        else $error("transaction taken while the whole pipeline is blocked");
`endif

endmodule
